>>> rtl/bia_pkg.sv
// Shared constants, codes and helper functions for the bitmap ID allocator.
// Depends on nothing; imported by bitmap_id_allocator_core and tb_top.
package bia_pkg;

   // Number of identifier slots tracked by the busy map.
   localparam int ID_COUNT = 4096;

   // The busy map is stored as words of WORD_BITS marks.
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORDS      = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SLOT_W     = WIDX_W + BIT_W;
   localparam int LAST_BITS  = ID_COUNT - (WORDS - 1) * WORD_BITS;

   // Field widths.
   localparam int BASE_W   = 15;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 2;

   localparam logic [BASE_W-1:0] ID_BASE_RESET = 15'd300;

   // Request type codes.
   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Marks of the last word that lie past the final slot; they always read as busy.
   function automatic logic [WORD_BITS-1:0] pad_mask();
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         m[i] = (i >= LAST_BITS);
      end
      return m;
   endfunction

   // Bit position of a one-hot word; each output bit is an independent OR.
   function automatic logic [BIT_W-1:0] onehot_index(logic [WORD_BITS-1:0] oh);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int k = 0; k < BIT_W; k++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            if (((i >> k) & 1) == 1) begin
               idx[k] = idx[k] | oh[i];
            end
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/bitmap_id_allocator_core.sv
// First-fit identifier allocator: request sequencer, word-wide busy map and
// result register. Depends on bia_pkg for sizes, codes and helper functions.
//
// Usage: a request transfer on the req_ channel either allocates the lowest
// free identifier (req_type allocate) or frees req_release_id (req_type
// release). Each request gives exactly one transfer on the rsp_ channel with
// the granted identifier (id_base plus slot) and a status code. The id_base
// register is written through csr_wr_en / csr_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// An allocation reads the busy map one 64-bit word per cycle from word zero
// until a word holds a free mark or the last word is checked. A release reads
// the word, writes it back and loads the result; a release out of range goes
// straight to the result. The word memory has one write port and a registered
// read. req_stall is high while a request is in work, so one request is
// handled at a time. A new request is taken while an earlier result still
// waits; a finished result waits in the sequencer while rsp_stall holds the
// output register full.
// Reset clears every busy mark at once through per-word valid bits, restores
// id_base to 300 and empties the result register.
module bitmap_id_allocator_core
   import bia_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [ID_W-1:0]     req_release_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ID_W-1:0]     rsp_granted_id,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_wr_en,
   input  logic [BASE_W-1:0]   csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_RD,
      ST_ALLOC_CHK,
      ST_REL_RD,
      ST_REL_WR,
      ST_FINISH
   } state_type;

   localparam logic [WIDX_W-1:0]    LAST_WORD = WIDX_W'(WORDS - 1);
   localparam logic [WORD_BITS-1:0] PAD_MASK  = pad_mask();

   state_type            state_ff, state_in;
   logic [BASE_W-1:0]    id_base_ff, id_base_in;
   logic [WIDX_W-1:0]    scan_ff, scan_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [WORDS-1:0]     word_vld_ff;
   logic                 vld_rd_ff;

   logic [WORD_BITS-1:0] mem_ff [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   logic                 mem_we;
   logic [WIDX_W-1:0]    mem_waddr;
   logic [WIDX_W-1:0]    mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata;

   logic [WORD_BITS-1:0] cur_word;
   logic [WORD_BITS-1:0] chk_word;
   logic [WORD_BITS-1:0] free_oh;
   logic [SLOT_W-1:0]    free_slot;
   logic [ID_W:0]        rel_diff;
   logic [ID_W:0]        grant_sum;

   // Word as stored; a word never written since reset reads as all free.
   assign cur_word = vld_rd_ff ? rd_data_ff : '0;

   // Search unit of the allocation: isolate the lowest zero mark with one add.
   assign chk_word  = cur_word | ((scan_ff == LAST_WORD) ? PAD_MASK : '0);
   assign free_oh   = ~chk_word & (chk_word + WORD_BITS'(1));
   assign free_slot = {scan_ff, onehot_index(free_oh)};
   assign grant_sum = (ID_W + 1)'(id_base_ff) + (ID_W + 1)'(free_slot);

   // Release offset from id_base; the top bit flags an id below the base.
   assign rel_diff = {1'b0, req_release_id} - (ID_W + 1)'(id_base_ff);

   // Sequencer next-state and result logic.
   always_comb begin
      state_in      = state_ff;
      id_base_in    = id_base_ff;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_ff;
      mem_wdata     = chk_word | free_oh;
      mem_raddr     = scan_ff;

      if (csr_wr_en) begin
         id_base_in = csr_wr_data;
      end

      // The output register empties on a result transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_ALLOC) begin
                  scan_in  = '0;
                  state_in = ST_ALLOC_RD;
               end else if (rel_diff[ID_W] || (rel_diff >= (ID_W + 1)'(ID_COUNT))) begin
                  res_id_in     = '0;
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_FINISH;
               end else begin
                  slot_in  = rel_diff[SLOT_W-1:0];
                  state_in = ST_REL_RD;
               end
            end
         end
         ST_ALLOC_RD: begin
            mem_raddr = scan_ff;
            state_in  = ST_ALLOC_CHK;
         end
         ST_ALLOC_CHK: begin
            if (free_oh != '0) begin
               mem_we        = 1'b1;
               mem_waddr     = scan_ff;
               mem_wdata     = chk_word | free_oh;
               res_id_in     = grant_sum[ID_W-1:0];
               res_status_in = STATUS_OK;
               state_in      = ST_FINISH;
            end else if (scan_ff == LAST_WORD) begin
               res_id_in     = '0;
               res_status_in = STATUS_FULL;
               state_in      = ST_FINISH;
            end else begin
               // Read the following word while this one is checked.
               scan_in   = scan_ff + WIDX_W'(1);
               mem_raddr = scan_ff + WIDX_W'(1);
            end
         end
         ST_REL_RD: begin
            mem_raddr = slot_ff[SLOT_W-1:BIT_W];
            state_in  = ST_REL_WR;
         end
         ST_REL_WR: begin
            mem_we        = 1'b1;
            mem_waddr     = slot_ff[SLOT_W-1:BIT_W];
            mem_wdata     = cur_word & ~(WORD_BITS'(1) << slot_ff[BIT_W-1:0]);
            res_id_in     = '0;
            res_status_in = STATUS_OK;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         id_base_ff   <= ID_BASE_RESET;
         rsp_valid_ff <= 1'b0;
         word_vld_ff  <= '0;
         vld_rd_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_base_ff   <= id_base_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_rd_ff    <= word_vld_ff[mem_raddr];
         if (mem_we) begin
            word_vld_ff[mem_waddr] <= 1'b1;
         end
      end
      scan_ff       <= scan_in;
      slot_ff       <= slot_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Busy map word memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef ASSERT_OFF
   // A new result only appears when the sequencer hands one over.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared without a finished request");

   // A result that is not a successful grant carries a zero identifier.
   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> (rsp_id_ff == '0))
      else $error("nonzero identifier on a failed request");

   // The busy map is only written at the end of an allocate or release.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_ALLOC_CHK) || (state_ff == ST_REL_WR)))
      else $error("busy map written outside an update step");

   // The scan never runs past the last word.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_CHK) |-> (scan_ff <= LAST_WORD))
      else $error("scan index past the last word");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for bitmap_id_allocator_core: a queue-fed driver, a
// stalling receiver and a first-fit predictor of the busy map.
// Depends on bia_pkg and the RTL of bitmap_id_allocator_core.
`timescale 1ns / 1ps

module tb_top;
   import bia_pkg::*;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] id;
   } id_request_type;

   typedef struct packed {
      logic [ID_W-1:0]     granted;
      logic [STATUS_W-1:0] status;
   } id_result_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid      = 1'b0;
   logic                req_type       = REQ_ALLOC;
   logic [ID_W-1:0]     req_release_id = '0;
   logic                rsp_stall      = 1'b0;
   logic                csr_wr_en      = 1'b0;
   logic [BASE_W-1:0]   csr_wr_data    = '0;
   logic                req_stall;
   logic                rsp_valid;
   logic [ID_W-1:0]     rsp_granted_id;
   logic [STATUS_W-1:0] rsp_status;

   id_request_type pending_requests[$];
   id_result_type  expected_results[$];

   // Predictor state: one busy mark per slot and the current base identifier.
   logic [ID_COUNT-1:0] slot_busy_shadow;
   logic [BASE_W-1:0]   base_shadow;

   // Base identifier that the stimulus generator aims its releases at.
   int stim_base = ID_BASE_RESET;

   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   int rsp_count = 0;
   int error_count = 0;

   bitmap_id_allocator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_release_id (req_release_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted_id (rsp_granted_id),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   // First-fit prediction of one request; updates the shadow busy map.
   function automatic id_result_type predict_grant(id_request_type r);
      id_result_type res;
      int            slot;
      int            offset;
      bit            found;
      res.granted = '0;
      res.status  = STATUS_OK;
      found = 1'b0;
      slot = 0;
      if (r.kind == REQ_ALLOC) begin
         for (int s = 0; s < ID_COUNT && !found; s++) begin
            if (!slot_busy_shadow[s]) begin
               found = 1'b1;
               slot = s;
            end
         end
         if (found) begin
            slot_busy_shadow[slot] = 1'b1;
            res.granted = ID_W'(int'(base_shadow) + slot);
         end else begin
            res.status = STATUS_FULL;
         end
      end else begin
         offset = int'(r.id) - int'(base_shadow);
         if (offset < 0 || offset >= ID_COUNT) begin
            res.status = STATUS_RANGE;
         end else begin
            slot_busy_shadow[offset] = 1'b0;
         end
      end
      return res;
   endfunction

   // Random request: mostly allocations and releases of ids in a window above
   // the base, with some out-of-range releases and fully random ids.
   function automatic id_request_type random_request(int window);
      id_request_type r;
      int             pick;
      pick = $urandom_range(0, 99);
      r.kind = REQ_RELEASE;
      r.id = ID_W'($urandom);
      if (pick < 45) begin
         r.kind = REQ_ALLOC;
      end else if (pick < 85) begin
         r.id = ID_W'(stim_base + $urandom_range(0, window - 1));
      end else if (pick < 92) begin
         if (stim_base > 0 && $urandom_range(0, 1) == 1) begin
            r.id = ID_W'($urandom_range(0, stim_base - 1));
         end else begin
            r.id = ID_W'($urandom_range(stim_base + ID_COUNT, 65535));
         end
      end
      return r;
   endfunction

   task automatic queue_request(logic kind, logic [ID_W-1:0] id);
      id_request_type r;
      r.kind = kind;
      r.id = id;
      pending_requests.push_back(r);
   endtask

   task automatic queue_random(int count, int window);
      repeat (count) pending_requests.push_back(random_request(window));
   endtask

   // Hold the sender until every queued request has its result.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   // The base register is written only while the block is idle.
   task automatic write_base(int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= BASE_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      stim_base = value;
      repeat (2) @(posedge clock);
   endtask

   // Request driver: bursts of transfers separated by random gaps.
   int burst_left = 8;
   int gap_left = 0;
   always @(negedge clock) begin
      id_request_type next_req;
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_type <= next_req.kind;
            req_release_id <= next_req.id;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall pattern changes every stretch; long hold-offs at
   // fixed result counts let the block fill up and stall its input.
   int hold_left = 0;
   int mode_left = 0;
   int stall_mode = 0;
   int phase_tick = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      phase_tick++;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (rsp_fire && (rsp_count == 150 || rsp_count == 400)) begin
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= phase_tick[0];
         endcase
      end
   end

   // Monitor: tracks configuration, checks results and predicts new ones.
   always @(posedge clock) begin
      id_result_type  want;
      id_request_type got_req;
      if (reset) begin
         slot_busy_shadow = '0;
         base_shadow = ID_BASE_RESET;
         req_fire = 1'b0;
         rsp_fire = 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_shadow = csr_wr_data;
         end
         rsp_fire = rsp_valid && !rsp_stall;
         req_fire = req_valid && !req_stall;
         if (rsp_fire) begin
            rsp_count++;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: result transfer with nothing expected: granted_id %0d status %0d",
                        $time, rsp_granted_id, rsp_status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_granted_id !== want.granted) begin
                  error_count++;
                  $display("%0t: granted_id mismatch: expected %0d actual %0d",
                           $time, want.granted, rsp_granted_id);
               end
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (req_fire) begin
            got_req.kind = req_type;
            got_req.id = req_release_id;
            expected_results.push_back(predict_grant(got_req));
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed checks at the reset base of 300.
      queue_request(REQ_ALLOC, 16'hFFFF);
      queue_request(REQ_ALLOC, 16'h0000);
      queue_request(REQ_ALLOC, 16'h5A5A);
      queue_request(REQ_RELEASE, 16'd301);
      // A second release of the same id is legal and changes nothing.
      queue_request(REQ_RELEASE, 16'd301);
      queue_request(REQ_ALLOC, 16'h0000);
      // Releases just below the base and just past the last slot.
      queue_request(REQ_RELEASE, 16'd299);
      queue_request(REQ_RELEASE, 16'(300 + ID_COUNT));
      queue_request(REQ_RELEASE, 16'(300 + ID_COUNT - 1));
      queue_request(REQ_RELEASE, 16'd0);
      queue_request(REQ_RELEASE, 16'hFFFF);
      queue_request(REQ_RELEASE, 16'd300);
      queue_request(REQ_ALLOC, 16'h0000);
      queue_request(REQ_RELEASE, 16'd302);
      queue_request(REQ_RELEASE, 16'd301);
      queue_request(REQ_RELEASE, 16'd300);
      wait_drained();

      // Allocate a run of slots at base zero, then free a few and refill.
      write_base(0);
      repeat (100) queue_request(REQ_ALLOC, ID_W'($urandom));
      queue_request(REQ_RELEASE, 16'(ID_COUNT - 1));
      queue_request(REQ_RELEASE, 16'(ID_COUNT));
      queue_request(REQ_RELEASE, 16'd0);
      queue_request(REQ_RELEASE, 16'd70);
      queue_request(REQ_ALLOC, 16'h0000);
      queue_request(REQ_ALLOC, 16'h0000);
      queue_request(REQ_ALLOC, 16'h0000);

      // Random traffic over the low slots, with a drain in the middle.
      queue_random(100, 256);
      wait_drained();
      queue_random(100, 256);
      wait_drained();

      // Highest base: identifiers run past 32767.
      write_base((1 << BASE_W) - 1);
      queue_random(120, 256);
      wait_drained();

      // A random base with releases aimed at the lowest slots.
      write_base($urandom_range(1, (1 << BASE_W) - 2));
      queue_random(100, 64);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
